FILE: sv/suv_pkg.sv
// Shared types, widths and constants of the spherical UV mapping pipeline.
package suv_pkg;

	localparam int COORD_BITS   = 16;
	localparam int UV_FRAC_BITS = 16;
	localparam int UV_BITS      = UV_FRAC_BITS + 1;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int NORM_BITS    = 31;
	localparam int SHIFT_BITS   = $clog2(NORM_BITS);
	localparam int SQ_BITS      = 2 * NORM_BITS;
	localparam int RAD_BITS     = 64;
	localparam int ROOT_BITS    = 32;
	localparam int SQRT_STEPS   = ROOT_BITS;
	localparam int Q_BITS       = UV_FRAC_BITS;
	localparam int NUM_BITS     = NORM_BITS + UV_FRAC_BITS + 1;
	localparam int STEPS_PER_ST = 4;
	localparam int CORDIC_STEPS = 28;
	localparam int CX_BITS      = 36;
	localparam int ANG_BITS     = 34;
	localparam int FRONT_LAT    = 3;
	localparam int SQRT_LAT     = 2 + SQRT_STEPS / STEPS_PER_ST;
	localparam int DIV_LAT      = Q_BITS / STEPS_PER_ST;
	localparam int CORDIC_LAT   = 1 + CORDIC_STEPS / STEPS_PER_ST;
	localparam int PIPE_LAT     = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic signed [COORD_BITS-1:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic [UV_BITS-1:0] tex_u;
		logic [UV_BITS-1:0] tex_v;
		logic               degenerate;
	} uv_t;

	typedef struct packed {
		logic dy_pos;
		logic xz_zero;
		logic degen;
	} side_t;

	typedef struct packed {
		logic [NORM_BITS-1:0]      sx;
		logic [NORM_BITS-1:0]      sy;
		logic [NORM_BITS-1:0]      sz;
		logic signed [NORM_BITS:0] cx;
		logic signed [NORM_BITS:0] cz;
		side_t                     side;
	} front_t;

	function automatic logic signed [ANG_BITS-1:0] turn_atan(input int unsigned i);
		logic signed [ANG_BITS-1:0] a;
		unique case (i)
			0:  a = 34'sd536870912;
			1:  a = 34'sd316933406;
			2:  a = 34'sd167458907;
			3:  a = 34'sd85004756;
			4:  a = 34'sd42667331;
			5:  a = 34'sd21354465;
			6:  a = 34'sd10679838;
			7:  a = 34'sd5340245;
			8:  a = 34'sd2670163;
			9:  a = 34'sd1335087;
			10: a = 34'sd667544;
			11: a = 34'sd333772;
			12: a = 34'sd166886;
			13: a = 34'sd83443;
			14: a = 34'sd41722;
			15: a = 34'sd20861;
			16: a = 34'sd10430;
			17: a = 34'sd5215;
			18: a = 34'sd2608;
			19: a = 34'sd1304;
			20: a = 34'sd652;
			21: a = 34'sd326;
			22: a = 34'sd163;
			23: a = 34'sd81;
			24: a = 34'sd41;
			25: a = 34'sd20;
			26: a = 34'sd10;
			27: a = 34'sd5;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: sv/suv_dly.sv
// Enabled shift-register delay line for side data riding along the pipeline.
module suv_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[N-1];

endmodule

FILE: sv/suv_front.sv
// Front end: direction, magnitudes, normalizing shift and scaled components.
module suv_front (
	input  logic                                   clk,
	input  logic                                   adv,
	input  suv_pkg::vertex_t                       vtx,
	input  logic signed [suv_pkg::COORD_BITS-1:0]  ctr_x,
	input  logic signed [suv_pkg::COORD_BITS-1:0]  ctr_y,
	input  logic signed [suv_pkg::COORD_BITS-1:0]  ctr_z,
	output suv_pkg::front_t                        fr
);

	localparam int DW = suv_pkg::DIFF_BITS;
	localparam int NB = suv_pkg::NORM_BITS;
	localparam int SB = suv_pkg::SHIFT_BITS;

	logic signed [DW-1:0] dx, dy, dz;
	logic [DW-1:0]        ax_s1, ay_s1, az_s1;
	logic                 nx_s1, nz_s1, dyp_s1, deg_s1;
	logic [DW-1:0]        ax_s2, ay_s2, az_s2, m_all, m_xz;
	logic                 nx_s2, nz_s2, dyp_s2, deg_s2, xzz_s2;
	logic [SB-1:0]        pos_all, pos_xz, sh_all_s2, sh_xz_s2;
	logic [NB-1:0]        cxm, czm;

	always_comb begin
		dx = DW'(ctr_x) - DW'(vtx.vertex_x);
		dy = DW'(ctr_y) - DW'(vtx.vertex_y);
		dz = DW'(ctr_z) - DW'(vtx.vertex_z);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			ay_s1  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
			az_s1  <= dz[DW-1] ? DW'(-dz) : DW'(dz);
			nx_s1  <= dx[DW-1];
			nz_s1  <= dz[DW-1];
			dyp_s1 <= ~dy[DW-1] & (dy != '0);
			deg_s1 <= (dx == '0) & (dy == '0) & (dz == '0);
		end
	end

	always_comb begin
		m_xz    = (ax_s1 > az_s1) ? ax_s1 : az_s1;
		m_all   = (m_xz > ay_s1) ? m_xz : ay_s1;
		pos_all = '0;
		pos_xz  = '0;
		for (int i = 0; i < DW; i++) begin
			if (m_all[i]) pos_all = SB'(i);
			if (m_xz[i]) pos_xz = SB'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
			az_s2     <= az_s1;
			nx_s2     <= nx_s1;
			nz_s2     <= nz_s1;
			dyp_s2    <= dyp_s1;
			deg_s2    <= deg_s1;
			xzz_s2    <= (ax_s1 == '0) & (az_s1 == '0);
			sh_all_s2 <= SB'(NB - 1) - pos_all;
			sh_xz_s2  <= SB'(NB - 1) - pos_xz;
		end
	end

	always_comb begin
		cxm = NB'(ax_s2) << sh_xz_s2;
		czm = NB'(az_s2) << sh_xz_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr.sx           <= NB'(ax_s2) << sh_all_s2;
			fr.sy           <= NB'(ay_s2) << sh_all_s2;
			fr.sz           <= NB'(az_s2) << sh_all_s2;
			fr.cx           <= nx_s2 ? -$signed({1'b0, cxm}) : $signed({1'b0, cxm});
			fr.cz           <= nz_s2 ? -$signed({1'b0, czm}) : $signed({1'b0, czm});
			fr.side.dy_pos  <= dyp_s2;
			fr.side.xz_zero <= xzz_s2;
			fr.side.degen   <= deg_s2;
		end
	end

endmodule

FILE: sv/suv_isqrt.sv
// Sum of squares and pipelined integer square root, four root bits a stage.
module suv_isqrt (
	input  logic                                clk,
	input  logic                                adv,
	input  logic [suv_pkg::NORM_BITS-1:0]       sx,
	input  logic [suv_pkg::NORM_BITS-1:0]       sy,
	input  logic [suv_pkg::NORM_BITS-1:0]       sz,
	output logic [suv_pkg::ROOT_BITS-1:0]       len
);

	localparam int RB = suv_pkg::RAD_BITS;
	localparam int SP = suv_pkg::STEPS_PER_ST;
	localparam int NS = suv_pkg::SQRT_STEPS / SP;

	logic [suv_pkg::SQ_BITS-1:0] qx_s1, qy_s1, qz_s1;
	logic [RB-1:0]               n_q [NS+1];
	logic [RB-1:0]               r_q [NS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1  <= sx * sx;
			qy_s1  <= sy * sy;
			qz_s1  <= sz * sz;
			n_q[0] <= RB'(qx_s1) + RB'(qy_s1) + RB'(qz_s1);
			r_q[0] <= '0;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [RB-1:0] n_c, r_c, b_c;

		always_comb begin
			n_c = n_q[g];
			r_c = r_q[g];
			b_c = '0;
			for (int j = 0; j < SP; j++) begin
				b_c = RB'(1) << (RB - 2 - 2 * (g * SP + j));
				if (n_c >= r_c + b_c) begin
					n_c = n_c - (r_c + b_c);
					r_c = (r_c >> 1) + b_c;
				end else begin
					r_c = r_c >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				n_q[g+1] <= n_c;
				r_q[g+1] <= r_c;
			end
		end
	end

	assign len = r_q[NS][suv_pkg::ROOT_BITS-1:0];

endmodule

FILE: sv/suv_div.sv
// Rounded quotient of the scaled vertical component by the length, pipelined.
module suv_div (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [suv_pkg::NORM_BITS-1:0] sy,
	input  logic [suv_pkg::ROOT_BITS-1:0] len,
	output logic [suv_pkg::Q_BITS-1:0]    q
);

	localparam int NW = suv_pkg::NUM_BITS;
	localparam int QB = suv_pkg::Q_BITS;
	localparam int SP = suv_pkg::STEPS_PER_ST;
	localparam int NS = QB / SP;

	logic [NW-1:0]                 rem_q [NS+1];
	logic [QB-1:0]                 quo_q [NS+1];
	logic [suv_pkg::ROOT_BITS-1:0] len_q [NS+1];

	always_comb begin
		rem_q[0] = (NW'(sy) << (suv_pkg::UV_FRAC_BITS - 1)) + NW'(len >> 1);
		quo_q[0] = '0;
		len_q[0] = len;
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [NW-1:0] r_c, dv_c;
		logic [QB-1:0] q_c;

		always_comb begin
			r_c  = rem_q[g];
			q_c  = quo_q[g];
			dv_c = '0;
			for (int j = 0; j < SP; j++) begin
				dv_c = NW'(len_q[g]) << (QB - 1 - (g * SP + j));
				if (r_c >= dv_c) begin
					r_c = r_c - dv_c;
					q_c[QB - 1 - (g * SP + j)] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[g+1] <= r_c;
				quo_q[g+1] <= q_c;
				len_q[g+1] <= len_q[g];
			end
		end
	end

	assign q = quo_q[NS];

endmodule

FILE: sv/suv_cordic.sv
// Vectoring CORDIC: angle of (x, z) in units of 2^-32 turn, four steps a stage.
module suv_cordic (
	input  logic                                 clk,
	input  logic                                 adv,
	input  logic signed [suv_pkg::NORM_BITS:0]   cx,
	input  logic signed [suv_pkg::NORM_BITS:0]   cz,
	output logic signed [suv_pkg::ANG_BITS-1:0]  ang
);

	localparam int XB = suv_pkg::CX_BITS;
	localparam int AB = suv_pkg::ANG_BITS;
	localparam int SP = suv_pkg::STEPS_PER_ST;
	localparam int NS = suv_pkg::CORDIC_STEPS / SP;
	localparam logic signed [AB-1:0] HALF_TURN = AB'(64'sd2147483648);

	logic signed [XB-1:0] x_q [NS+1];
	logic signed [XB-1:0] z_q [NS+1];
	logic signed [AB-1:0] a_q [NS+1];
	logic signed [XB-1:0] xe, ze;

	assign xe = XB'(cx);
	assign ze = XB'(cz);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (xe < 0) begin
				x_q[0] <= -xe;
				z_q[0] <= -ze;
				a_q[0] <= (ze >= 0) ? HALF_TURN : -HALF_TURN;
			end else begin
				x_q[0] <= xe;
				z_q[0] <= ze;
				a_q[0] <= '0;
			end
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic signed [XB-1:0] x_c, z_c, nx_c, nz_c;
		logic signed [AB-1:0] a_c;

		always_comb begin
			x_c  = x_q[g];
			z_c  = z_q[g];
			a_c  = a_q[g];
			nx_c = '0;
			nz_c = '0;
			for (int j = 0; j < SP; j++) begin
				if (z_c >= 0) begin
					nx_c = x_c + (z_c >>> (g * SP + j));
					nz_c = z_c - (x_c >>> (g * SP + j));
					a_c  = a_c + suv_pkg::turn_atan(g * SP + j);
				end else begin
					nx_c = x_c - (z_c >>> (g * SP + j));
					nz_c = z_c + (x_c >>> (g * SP + j));
					a_c  = a_c - suv_pkg::turn_atan(g * SP + j);
				end
				x_c = nx_c;
				z_c = nz_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_q[g+1] <= x_c;
				z_q[g+1] <= z_c;
				a_q[g+1] <= a_c;
			end
		end
	end

	assign ang = a_q[NS];

endmodule

FILE: sv/spherical_uv_from_vertex.sv
// Spherical UV mapping of mesh vertices about a configurable center.
// Depth: 18 register stages between an accepted vertex and its result.
// Throughput: one vertex per cycle; the whole pipeline holds while a result is stalled.
// The sum of squares with square root (10 stages) and the divider (4 stages) set the depth.
// Reset clears the valid bits and the center registers to zero; input stalls during reset.
module spherical_uv_from_vertex (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [suv_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [suv_pkg::COORD_BITS-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  suv_pkg::vertex_t                      in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output suv_pkg::uv_t                          out_item
);

	localparam int LAT = suv_pkg::PIPE_LAT;
	localparam int UB  = suv_pkg::UV_BITS;
	localparam int AB  = suv_pkg::ANG_BITS;
	localparam int FB  = suv_pkg::UV_FRAC_BITS;
	localparam int SW  = $bits(suv_pkg::side_t);
	localparam logic signed [AB-1:0]   ROUND_A = AB'(1) <<< (31 - FB);
	localparam logic signed [AB-1:0]   HALF_A  = AB'(1) <<< (FB - 1);
	localparam logic signed [AB-1:0]   ONE_A   = AB'(1) <<< FB;
	localparam logic signed [UB+1:0]   HALF_V  = (UB + 2)'(1) <<< (FB - 1);
	localparam logic signed [UB+1:0]   ONE_V   = (UB + 2)'(1) <<< FB;
	localparam logic [UB-1:0]          HALF_U  = UB'(1) << (FB - 1);

	logic                                  adv;
	logic [LAT-1:0]                        vld_q;
	logic signed [suv_pkg::COORD_BITS-1:0] ctr_x_q, ctr_y_q, ctr_z_q;
	suv_pkg::front_t                       fr;
	suv_pkg::side_t                        side_d;
	logic [suv_pkg::ROOT_BITS-1:0]         len;
	logic [suv_pkg::NORM_BITS-1:0]         sy_d;
	logic [suv_pkg::Q_BITS-1:0]            q;
	logic signed [AB-1:0]                  ang, ang_d, ut, us;
	logic signed [UB+1:0]                  vs;
	suv_pkg::uv_t                          res, out_q;

	assign adv       = ~(vld_q[LAT-1] & out_stall);
	assign in_stall  = ~adv | ~arst_n;
	assign out_valid = vld_q[LAT-1];
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			ctr_z_q <= '0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
			if (cfg_we) begin
				unique case (cfg_index)
					suv_pkg::REG_CENTER_X: ctr_x_q <= cfg_data;
					suv_pkg::REG_CENTER_Y: ctr_y_q <= cfg_data;
					suv_pkg::REG_CENTER_Z: ctr_z_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	suv_front u_front (
		.clk   (clk),
		.adv   (adv),
		.vtx   (in_item),
		.ctr_x (ctr_x_q),
		.ctr_y (ctr_y_q),
		.ctr_z (ctr_z_q),
		.fr    (fr)
	);

	suv_isqrt u_isqrt (
		.clk (clk),
		.adv (adv),
		.sx  (fr.sx),
		.sy  (fr.sy),
		.sz  (fr.sz),
		.len (len)
	);

	suv_dly #(.W(suv_pkg::NORM_BITS), .N(suv_pkg::SQRT_LAT)) u_dly_sy (
		.clk (clk),
		.adv (adv),
		.d   (fr.sy),
		.q   (sy_d)
	);

	suv_div u_div (
		.clk (clk),
		.adv (adv),
		.sy  (sy_d),
		.len (len),
		.q   (q)
	);

	suv_cordic u_cordic (
		.clk (clk),
		.adv (adv),
		.cx  (fr.cx),
		.cz  (fr.cz),
		.ang (ang)
	);

	suv_dly #(.W(AB), .N(suv_pkg::SQRT_LAT + suv_pkg::DIV_LAT - suv_pkg::CORDIC_LAT))
	u_dly_ang (
		.clk (clk),
		.adv (adv),
		.d   (ang),
		.q   (ang_d)
	);

	suv_dly #(.W(SW), .N(suv_pkg::SQRT_LAT + suv_pkg::DIV_LAT)) u_dly_side (
		.clk (clk),
		.adv (adv),
		.d   (fr.side),
		.q   (side_d)
	);

	always_comb begin
		ut = ang_d + ROUND_A;
		us = HALF_A + (ut >>> (32 - FB));
		vs = side_d.dy_pos ? (HALF_V - (UB + 2)'(q)) : (HALF_V + (UB + 2)'(q));
		res.degenerate = side_d.degen;
		if (side_d.degen) begin
			res.tex_u = HALF_U;
			res.tex_v = HALF_U;
		end else begin
			if (side_d.xz_zero) begin
				res.tex_u = HALF_U;
			end else if (us < 0) begin
				res.tex_u = '0;
			end else if (us > ONE_A) begin
				res.tex_u = ONE_A[UB-1:0];
			end else begin
				res.tex_u = us[UB-1:0];
			end
			if (vs < 0) begin
				res.tex_v = '0;
			end else if (vs > ONE_V) begin
				res.tex_v = ONE_V[UB-1:0];
			end else begin
				res.tex_v = vs[UB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

endmodule

FILE: sim/suv_checker.sv
// Checker for the spherical UV block: predicts each result and compares it.
`timescale 1ns / 100ps
module suv_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [suv_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [suv_pkg::COORD_BITS-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  suv_pkg::vertex_t                 in_item,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  suv_pkg::uv_t                     out_item,
	output int                               errors,
	output int                               pending,
	output int                               results_seen,
	output int                               degenerate_seen
);

	localparam longint HALF = longint'(1) << (suv_pkg::UV_FRAC_BITS - 1);
	localparam longint ONE  = longint'(1) << suv_pkg::UV_FRAC_BITS;

	logic signed [suv_pkg::COORD_BITS-1:0] center [3];
	suv_pkg::uv_t expected_uv [$];

	function automatic int scale_to_norm(longint unsigned m);
		int s;
		s = 0;
		while (m >= (64'd1 << 31)) begin
			m = m >> 1;
			s--;
		end
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			s++;
		end
		return s;
	endfunction

	function automatic longint unsigned shift_by(longint unsigned m, int s);
		return (s >= 0) ? (m << s) : (m >> (-s));
	endfunction

	function automatic longint floor_div2(longint v, int i);
		return v >>> i;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint turn_angle(longint x, longint z);
		longint acc, nx, nz;
		acc = 0;
		if (x < 0) begin
			acc = (z >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
			x = -x;
			z = -z;
		end
		for (int i = 0; i < suv_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x + floor_div2(z, i);
				nz = z - floor_div2(x, i);
				acc += longint'(suv_pkg::turn_atan(i));
			end else begin
				nx = x - floor_div2(z, i);
				nz = z + floor_div2(x, i);
				acc -= longint'(suv_pkg::turn_atan(i));
			end
			x = nx;
			z = nz;
		end
		return acc;
	endfunction

	function automatic suv_pkg::uv_t map_vertex(suv_pkg::vertex_t vtx);
		suv_pkg::uv_t r;
		longint dx, dy, dz, u, v, cx, cz;
		longint unsigned ax, ay, az, m, sx, sy, sz, len, q;
		int s;
		dx = longint'(center[0]) - longint'(vtx.vertex_x);
		dy = longint'(center[1]) - longint'(vtx.vertex_y);
		dz = longint'(center[2]) - longint'(vtx.vertex_z);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		r.degenerate = 1'b0;
		if (ax == 0 && ay == 0 && az == 0) begin
			r.tex_u = suv_pkg::UV_BITS'(HALF);
			r.tex_v = suv_pkg::UV_BITS'(HALF);
			r.degenerate = 1'b1;
			return r;
		end
		m = ax > ay ? ax : ay;
		if (az > m) m = az;
		s = scale_to_norm(m);
		sx = shift_by(ax, s);
		sy = shift_by(ay, s);
		sz = shift_by(az, s);
		len = int_sqrt(sx * sx + sy * sy + sz * sz);
		q = ((sy << (suv_pkg::UV_FRAC_BITS - 1)) + (len >> 1)) / len;
		v = (dy > 0) ? HALF - longint'(q) : HALF + longint'(q);
		if (v < 0) v = 0;
		if (v > ONE) v = ONE;
		u = HALF;
		if (ax != 0 || az != 0) begin
			m = ax > az ? ax : az;
			s = scale_to_norm(m);
			cx = longint'(shift_by(ax, s));
			cz = longint'(shift_by(az, s));
			if (dx < 0) cx = -cx;
			if (dz < 0) cz = -cz;
			u = HALF + floor_div2(turn_angle(cx, cz)
				+ (longint'(1) << (31 - suv_pkg::UV_FRAC_BITS)),
				32 - suv_pkg::UV_FRAC_BITS);
			if (u < 0) u = 0;
			if (u > ONE) u = ONE;
		end
		r.tex_u = suv_pkg::UV_BITS'(u);
		r.tex_v = suv_pkg::UV_BITS'(v);
		return r;
	endfunction

	assign pending = expected_uv.size();

	always @(posedge clk or negedge arst_n) begin
		suv_pkg::uv_t want;
		if (!arst_n) begin
			center[0] = '0;
			center[1] = '0;
			center[2] = '0;
			errors = 0;
			results_seen = 0;
			degenerate_seen = 0;
			expected_uv.delete();
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (out_item.degenerate) degenerate_seen++;
				if (expected_uv.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result u=%0d v=%0d deg=%0b", out_item.tex_u,
							out_item.tex_v, out_item.degenerate);
				end else begin
					want = expected_uv.pop_front();
					if (out_item !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected u=%0d v=%0d deg=%0b, got u=%0d v=%0d deg=%0b",
								want.tex_u, want.tex_v, want.degenerate, out_item.tex_u,
								out_item.tex_v, out_item.degenerate);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_uv = {expected_uv, map_vertex(in_item)};
			if (cfg_we) begin
				case (cfg_index)
					suv_pkg::REG_CENTER_X: center[0] = cfg_data;
					suv_pkg::REG_CENTER_Y: center[1] = cfg_data;
					suv_pkg::REG_CENTER_Z: center[2] = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: sim/tb_spherical_uv_from_vertex.sv
// Testbench top: drives vertices and center settings, gives the verdict.
`timescale 1ns / 100ps
module tb_spherical_uv_from_vertex;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [suv_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [suv_pkg::COORD_BITS-1:0]   cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	suv_pkg::vertex_t                 in_item = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	suv_pkg::uv_t                     out_item;
	int                               errors, pending, results_seen, degenerate_seen;
	logic                             hold_off = 1'b0;
	int                               items_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	spherical_uv_from_vertex dut (.*);

	suv_checker u_checker (.*);

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if ($urandom_range(0, 3) == 0) out_stall <= ~out_stall;
		else if (results_seen > 300) out_stall <= 1'b0;
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

	task automatic write_center(logic [suv_pkg::CFG_IDX_BITS-1:0] idx,
		logic [suv_pkg::COORD_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_center(logic [suv_pkg::COORD_BITS-1:0] x,
		logic [suv_pkg::COORD_BITS-1:0] y, logic [suv_pkg::COORD_BITS-1:0] z);
		write_center(suv_pkg::REG_CENTER_X, x);
		write_center(suv_pkg::REG_CENTER_Y, y);
		write_center(suv_pkg::REG_CENTER_Z, z);
		write_center(2'd3, 16'h5a5a);
	endtask

	task automatic send_vertex(logic [suv_pkg::COORD_BITS-1:0] x,
		logic [suv_pkg::COORD_BITS-1:0] y, logic [suv_pkg::COORD_BITS-1:0] z, bit gap);
		in_valid <= 1'b1;
		in_item <= {x, y, z};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (gap) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [suv_pkg::COORD_BITS-1:0] rand_coord(
		logic [suv_pkg::COORD_BITS-1:0] c);
		case ($urandom_range(0, 5))
			0: return c;
			1: return c + suv_pkg::COORD_BITS'($urandom_range(0, 6)) - 16'd3;
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return suv_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	task automatic random_phase(int count, logic [suv_pkg::COORD_BITS-1:0] cx,
		logic [suv_pkg::COORD_BITS-1:0] cy, logic [suv_pkg::COORD_BITS-1:0] cz);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) burst = $urandom_range(1, 20);
			burst--;
			if ($urandom_range(0, 15) == 0)
				send_vertex(cx, cy, cz, burst == 0);
			else if ($urandom_range(0, 9) == 0)
				send_vertex(cx + suv_pkg::COORD_BITS'($urandom_range(0, 2)) - 16'd1,
					rand_coord(cy),
					cz + suv_pkg::COORD_BITS'($urandom_range(0, 2)) - 16'd1, burst == 0);
			else
				send_vertex(rand_coord(cx), rand_coord(cy), rand_coord(cz), burst == 0);
		end
		drain();
	endtask

	initial begin
		logic [suv_pkg::COORD_BITS-1:0] cx, cy, cz;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_vertex(16'h0000, 16'h0000, 16'h0000, 0);
		send_vertex(16'h0000, 16'h0100, 16'h0000, 0);
		send_vertex(16'h0000, 16'hff00, 16'h0000, 0);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 0);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_vertex(16'h0001, 16'h0000, 16'h0000, 0);
		send_vertex(16'hffff, 16'h0000, 16'h0000, 0);
		send_vertex(16'hffff, 16'h0000, 16'h0001, 0);
		send_vertex(16'hffff, 16'h0000, 16'hffff, 0);
		send_vertex(16'h0000, 16'h0000, 16'h0001, 0);
		send_vertex(16'h0000, 16'h0000, 16'hffff, 0);
		send_vertex(16'h1234, 16'h1234, 16'h1234, 0);
		drain();

		set_center(16'h7fff, 16'h7fff, 16'h7fff);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 0);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_vertex(16'h7fff, 16'h8000, 16'h7fff, 0);
		send_vertex(16'h8000, 16'h7fff, 16'h7fff, 0);
		drain();

		set_center(16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 0);
		send_vertex(16'h8000, 16'h7fff, 16'h8000, 0);
		send_vertex(16'h8000, 16'h8000, 16'h7fff, 0);
		drain();

		// hold the output long enough to back the pipeline up
		hold_off <= 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off <= 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_vertex(rand_coord(16'h8000), suv_pkg::COORD_BITS'($urandom),
					rand_coord(16'h8000), 0);
		join
		drain();

		for (int p = 0; p < 4; p++) begin
			cx = suv_pkg::COORD_BITS'($urandom);
			cy = suv_pkg::COORD_BITS'($urandom);
			cz = suv_pkg::COORD_BITS'($urandom);
			set_center(cx, cy, cz);
			random_phase(95, cx, cy, cz);
		end

		set_center(16'h0000, 16'h0000, 16'h0000);
		random_phase(20, 16'h0000, 16'h0000, 16'h0000);

		repeat (30) @(posedge clk);
		$display("sent %0d vertices over 8 center settings, %0d results, %0d degenerate",
			items_sent, results_seen, degenerate_seen);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
